// ----- rtl/rall_pkg.sv -----
package rall_pkg;

  // Width of one stored device address
  localparam int unsigned ADDR_W = 48;

  // Width of the reported entry count
  localparam int unsigned COUNT_W = 4;

  // Width of the read position field
  localparam int unsigned POS_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;

  // Request function codes
  typedef enum logic [1:0] {
    FUNC_TOUCH  = 2'd0,
    FUNC_FORGET = 2'd1,
    FUNC_READ   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

endpackage

// ----- rtl/rall_slot_ram.sv -----
module rall_slot_ram #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IW    = 3
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IW-1:0]   waddr_i,
  input  rall_pkg::addr_t wdata_i,
  input  logic            re_i,
  input  logic [IW-1:0]   raddr_i,
  output rall_pkg::addr_t rdata_o
);
  import rall_pkg::*;

  addr_t mem_q [DEPTH];
  addr_t rdata_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/recent_address_list_lru.sv -----
// Most-recent-first list of device addresses with move-to-front replacement.
//
// A request is taken at a rising edge with start_i high and busy_o low; it
// carries func_i (touch, forget, read position), device_address_i and
// position_i. busy_o stays high while the request is worked on, and the
// result appears on found_o, evicted_o, entry_count_o, read_valid_o and
// read_address_o, marked by done_o for exactly one cycle. The receiver cannot
// hold a result off; a new request may be taken in the cycle done_o is high.
//
// The list lives in a one-write, one-read slot memory with registered read
// data, so every entry visit is a read state followed by a state that uses
// the data, through that single read port. A touch or forget first scans the
// list (read, compare per entry checked), then moves entries one slot at a
// time (check, read, write). A read of a valid position goes through a read
// state and a wait state; a read beyond the count or an unused function code
// is answered from idle without busy_o going high. One request is in work at
// a time.
//
// Reset clears count and state, not slots; slots are written before read.
module recent_address_list_lru #(
  parameter int unsigned LIST_DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         func_i,
  input  rall_pkg::addr_t                    device_address_i,
  input  logic [rall_pkg::POS_W-1:0]         position_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic                               evicted_o,
  output logic [rall_pkg::COUNT_W-1:0]       entry_count_o,
  output logic                               read_valid_o,
  output rall_pkg::addr_t                    read_address_o
);
  import rall_pkg::*;

  localparam int unsigned IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW   = (CW > POS_W) ? CW : POS_W;
  localparam int unsigned EW   = (CW > COUNT_W) ? CW : COUNT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_CHK,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_HEAD_WR,
    ST_READ_RD,
    ST_READ_WAIT
  } state_e;

  state_e        state_q;
  func_e         func_q;
  addr_t         addr_q;
  logic [IW-1:0] pos_idx_q;
  logic [CW-1:0] count_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] k_q;
  logic          done_q;
  logic          found_q;
  logic          evicted_q;
  logic          rvalid_q;
  addr_t         raddr_q;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  addr_t         ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  addr_t         ram_rdata;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] count_pext;
  logic          pos_ok;
  logic [EW-1:0] count_wide;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] k_dec;

  rall_slot_ram #(
    .DEPTH (LIST_DEPTH),
    .IW    (IW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Check the read position against the count and the depth
  assign pos_ext    = PW'(position_i);
  assign count_pext = PW'(count_q);
  assign pos_ok     = (pos_ext < count_pext) && (pos_ext < PW'(LIST_DEPTH));

  assign k_inc = k_q + CW'(1);
  assign k_dec = k_q - CW'(1);

  // Drive the slot memory from the sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k_q[IW-1:0];
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = idx_q[IW-1:0];
    case (state_q)
      ST_SRCH_RD: begin
        ram_re = (idx_q < count_q);
      end
      ST_MOVE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = (func_q == FUNC_TOUCH) ? k_dec[IW-1:0] : k_inc[IW-1:0];
      end
      ST_MOVE_WR: begin
        ram_we = 1'b1;
      end
      ST_HEAD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = addr_q;
      end
      ST_READ_RD: begin
        ram_re    = 1'b1;
        ram_raddr = pos_idx_q;
      end
      default: begin
      end
    endcase
  end

  // Sequence one request and register its result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      done_q    <= 1'b0;
      func_q    <= FUNC_TOUCH;
      addr_q    <= '0;
      pos_idx_q <= '0;
      idx_q     <= '0;
      k_q       <= '0;
      found_q   <= 1'b0;
      evicted_q <= 1'b0;
      rvalid_q  <= 1'b0;
      raddr_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            func_q    <= func_e'(func_i);
            addr_q    <= device_address_i;
            pos_idx_q <= pos_ext[IW-1:0];
            idx_q     <= '0;
            found_q   <= 1'b0;
            evicted_q <= 1'b0;
            rvalid_q  <= 1'b0;
            raddr_q   <= '0;
            case (func_e'(func_i))
              FUNC_TOUCH, FUNC_FORGET: begin
                state_q <= ST_SRCH_RD;
              end
              FUNC_READ: begin
                if (pos_ok) begin
                  state_q <= ST_READ_RD;
                end else begin
                  done_q <= 1'b1;
                end
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        ST_SRCH_RD: begin
          if (idx_q < count_q) begin
            state_q <= ST_SRCH_CMP;
          end else if (func_q == FUNC_TOUCH) begin
            // Miss on touch: grow the list or drop the oldest
            if (count_q < CW'(LIST_DEPTH)) begin
              k_q     <= count_q;
              count_q <= count_q + CW'(1);
            end else begin
              k_q       <= CW'(LIST_DEPTH - 1);
              evicted_q <= 1'b1;
            end
            state_q <= ST_SHIFT_CHK;
          end else begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_SRCH_CMP: begin
          if (ram_rdata == addr_q) begin
            found_q <= 1'b1;
            k_q     <= idx_q;
            state_q <= ST_SHIFT_CHK;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= ST_SRCH_RD;
          end
        end
        ST_SHIFT_CHK: begin
          if (func_q == FUNC_TOUCH) begin
            state_q <= (k_q == '0) ? ST_HEAD_WR : ST_MOVE_RD;
          end else if (k_inc < count_q) begin
            state_q <= ST_MOVE_RD;
          end else begin
            // Gap closed: shrink the list
            count_q <= count_q - CW'(1);
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_MOVE_RD: begin
          state_q <= ST_MOVE_WR;
        end
        ST_MOVE_WR: begin
          k_q     <= (func_q == FUNC_TOUCH) ? k_dec : k_inc;
          state_q <= ST_SHIFT_CHK;
        end
        ST_HEAD_WR: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_READ_RD: begin
          state_q <= ST_READ_WAIT;
        end
        ST_READ_WAIT: begin
          rvalid_q <= 1'b1;
          raddr_q  <= ram_rdata;
          done_q   <= 1'b1;
          state_q  <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Present the result; the count is already updated when done_o is high
  assign count_wide     = EW'(count_q);
  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign found_o        = found_q;
  assign evicted_o      = evicted_q;
  assign entry_count_o  = count_wide[COUNT_W-1:0];
  assign read_valid_o   = rvalid_q;
  assign read_address_o = raddr_q;

endmodule
